@@ src/md5_message_digest_defines.svh @@
// Assertion macros shared by the md5 digest modules.
`ifndef MD5_MESSAGE_DIGEST_DEFINES_SVH
`define MD5_MESSAGE_DIGEST_DEFINES_SVH
// Implication check on the design clock, muted while reset is held.
`define MD5_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("md5 check failed");
// Next-cycle implication check.
`define MD5_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("md5 check failed");
`endif

@@ src/md5_pkg.sv @@
// Package: types, constants and round tables for the md5 digest block.
`timescale 1ns / 1ps
`default_nettype none
package md5_pkg;
    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_PAD,
        ST_OUT_LO,
        ST_OUT_HI
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic       take_byte;   // write data byte into block, advance count
        logic       pad_start;   // begin padding: mark pad byte at fill position
        logic       pad_fill;    // write padding/length byte at fill position
        logic       round_start;
        logic       round_step;
        logic       chain_init;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic       block_full;  // fill position is byte 63: the next data write fills the block
        logic       round_done;
        logic       pad_last;    // current pad write is byte 63
        logic       final_blk;   // running compression is the last of the message
    } t_stat;

    function automatic logic [31:0] round_k(input logic [5:0] r);
        logic [31:0] k;
        case (r)
            6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
            6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
            6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
            6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
            6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] round_s(input logic [5:0] r);
        logic [4:0] s;
        case ({r[5:4], r[1:0]})
            4'h0: s = 5'd7;  4'h1: s = 5'd12; 4'h2: s = 5'd17; 4'h3: s = 5'd22;
            4'h4: s = 5'd5;  4'h5: s = 5'd9;  4'h6: s = 5'd14; 4'h7: s = 5'd20;
            4'h8: s = 5'd4;  4'h9: s = 5'd11; 4'ha: s = 5'd16; 4'hb: s = 5'd23;
            4'hc: s = 5'd6;  4'hd: s = 5'd10; 4'he: s = 5'd15; 4'hf: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    // message word index used by round r
    function automatic logic [3:0] round_g(input logic [5:0] r);
        logic [3:0] g;
        case (r[5:4])
            2'd0: g = r[3:0];
            2'd1: g = 4'(5 * r[3:0] + 1);
            2'd2: g = 4'(3 * r[3:0] + 5);
            2'd3: g = 4'(7 * r[3:0]);
            default: g = 4'd0;
        endcase
        return g;
    endfunction
endpackage
`default_nettype wire

@@ src/md5_stream_if.sv @@
// Valid/ready stream interface carrying one payload word.
`timescale 1ns / 1ps
`default_nettype none
interface md5_stream_if #(parameter int Width = 8);
    logic             valid;
    logic             ready;
    logic [Width-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ src/md5_ctrl.sv @@
// Controller state machine: byte intake, round sequencing, padding, digest output.
`timescale 1ns / 1ps
`default_nettype none
`include "md5_message_digest_defines.svh"
module md5_ctrl import md5_pkg::*; (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_valid,
    input  wire   i_has_byte,
    input  wire   i_last_byte,
    output logic  o_ready,
    output logic  o_out_valid,
    output logic  o_out_hi,
    input  wire   i_out_ready,
    output t_cmd  o_cmd,
    input  t_stat i_stat
);
    t_state r_state, n_state;
    logic   r_padding, n_padding;   // rounds belong to the final padded blocks
    logic   acc;

    assign acc = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_padding <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_padding <= n_padding;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_padding = r_padding;
        case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    if (i_has_byte && i_stat.block_full) begin
                        n_state   = ST_ROUND;
                        n_padding = i_last_byte;
                    end else if (i_last_byte) begin
                        n_state   = ST_PAD;
                        n_padding = 1'b1;
                    end
                end
            end
            ST_ROUND: begin
                if (i_stat.round_done) begin
                    if (!r_padding) begin
                        n_state = ST_IDLE;
                    end else if (i_stat.final_blk) begin
                        n_state = ST_OUT_LO;
                    end else begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                if (i_stat.pad_last) begin
                    n_state = ST_ROUND;
                end
            end
            ST_OUT_LO: if (i_out_ready) n_state = ST_OUT_HI;
            ST_OUT_HI: if (i_out_ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // rounds start on the last pad write, so they read the completed block
    always_comb begin
        o_cmd       = '0;
        o_ready     = 1'b0;
        o_out_valid = 1'b0;
        o_out_hi    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready           = 1'b1;
                o_cmd.take_byte   = acc && i_has_byte;
                o_cmd.pad_start   = acc && i_last_byte;
                o_cmd.round_start = acc && i_has_byte && i_stat.block_full;
            end
            ST_ROUND: o_cmd.round_step = 1'b1;
            ST_PAD: begin
                o_cmd.pad_fill    = 1'b1;
                o_cmd.round_start = i_stat.pad_last;
            end
            ST_OUT_LO: o_out_valid = 1'b1;
            ST_OUT_HI: begin
                o_out_valid     = 1'b1;
                o_out_hi        = 1'b1;
                o_cmd.chain_init = i_out_ready;
            end
            default: ;
        endcase
    end

    `MD5_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, o_ready, r_state == ST_IDLE)
    `MD5_ASSERT_NXT(a_hi_follows, i_clk, i_rst_n,
        (r_state == ST_OUT_LO) && i_out_ready, r_state == ST_OUT_HI)
    `MD5_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)
endmodule
`default_nettype wire

@@ src/md5_datapath.sv @@
// Datapath: block store, byte count, round unit and chaining words.
`timescale 1ns / 1ps
`default_nettype none
`include "md5_message_digest_defines.svh"
module md5_datapath import md5_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire  [7:0]  i_data_byte,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    output logic [127:0] o_digest
);
    logic [31:0] r_w [16];        // block store as little-endian message words
    logic [60:0] r_total, n_total;
    logic [31:0] r_ch [4];
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [5:0]  r_rnd;
    logic [5:0]  r_ppos;          // padding write position
    logic        r_mark;          // next pad write carries the 0x80 byte
    logic        r_len_blk;       // current pad block carries the length
    logic        r_fin;           // last compression of the message is running
    logic [63:0] bits;
    logic [7:0]  pad_val;
    logic [5:0]  pos;
    logic [31:0] w_g, f, t, rot;
    logic [3:0]  g;
    logic [4:0]  s;

    assign pos  = r_total[5:0];
    assign bits = {r_total, 3'b000};
    assign n_total = r_total + 61'd1;

    assign o_stat.block_full = (pos == 6'd63);
    assign o_stat.round_done = (r_rnd == 6'd63);
    assign o_stat.pad_last   = (r_ppos == 6'd63);
    assign o_stat.final_blk  = r_fin;
    assign o_digest = {r_ch[3], r_ch[2], r_ch[1], r_ch[0]};

    // length bytes only in a block whose pad byte left room (pos < 56), or in the zero block after one
    always_comb begin
        if (r_mark) begin
            pad_val = PAD_BYTE;
        end else if (r_len_blk && r_ppos >= 6'd56) begin
            pad_val = bits[8*(r_ppos[2:0]) +: 8];
        end else begin
            pad_val = 8'h00;
        end
    end

    assign g   = round_g(r_rnd);
    assign s   = round_s(r_rnd);
    assign w_g = r_w[g];
    always_comb begin
        case (r_rnd[5:4])
            2'd0: f = (r_b & r_c) | (~r_b & r_d);
            2'd1: f = (r_b & r_d) | (r_c & ~r_d);
            2'd2: f = r_b ^ r_c ^ r_d;
            default: f = r_c ^ (r_b | ~r_d);
        endcase
    end
    assign t   = r_a + f + w_g + round_k(r_rnd);
    assign rot = (t << s) | (t >> (6'd32 - {1'b0, s}));

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_byte) r_w[pos[5:2]][{pos[1:0], 3'b000} +: 8] <= i_data_byte;
        if (i_cmd.pad_start) begin
            r_ppos <= i_cmd.take_byte ? n_total[5:0] : pos;
            r_mark <= 1'b1;
        end else if (i_cmd.pad_fill) begin
            r_w[r_ppos[5:2]][{r_ppos[1:0], 3'b000} +: 8] <= pad_val;
            r_ppos <= r_ppos + 6'd1;
            r_mark <= 1'b0;
        end
        if (i_cmd.round_start) begin
            r_a <= r_ch[0]; r_b <= r_ch[1]; r_c <= r_ch[2]; r_d <= r_ch[3];
        end else if (i_cmd.round_step) begin
            r_a <= r_d; r_d <= r_c; r_c <= r_b; r_b <= rot + r_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total   <= '0;
            r_rnd     <= '0;
            r_len_blk <= 1'b0;
            r_fin     <= 1'b0;
            r_ch[0] <= INIT_A; r_ch[1] <= INIT_B; r_ch[2] <= INIT_C; r_ch[3] <= INIT_D;
        end else begin
            if (i_cmd.take_byte) r_total <= n_total;
            if (i_cmd.pad_start) begin
                r_len_blk <= ((i_cmd.take_byte ? n_total[5:0] : pos) < 6'd56);
                r_fin     <= 1'b0;
            end
            if (i_cmd.pad_fill && o_stat.pad_last) r_fin <= r_len_blk;
            if (i_cmd.round_step) begin
                r_rnd <= r_rnd + 6'd1;
                if (o_stat.round_done) begin
                    r_ch[0] <= r_ch[0] + r_d;
                    r_ch[1] <= r_ch[1] + rot + r_b;
                    r_ch[2] <= r_ch[2] + r_b;
                    r_ch[3] <= r_ch[3] + r_c;
                    // a pad block without length is followed by a zero block
                    if (!r_fin && r_len_blk == 1'b0) r_len_blk <= 1'b1;
                end
            end
            if (i_cmd.chain_init) begin
                r_ch[0] <= INIT_A; r_ch[1] <= INIT_B;
                r_ch[2] <= INIT_C; r_ch[3] <= INIT_D;
                r_total <= '0;
                r_fin   <= 1'b0;
            end
        end
    end

    `MD5_ASSERT_NXT(a_rnd_wrap, i_clk, i_rst_n,
        i_cmd.round_step && o_stat.round_done, r_rnd == 6'd0)
endmodule
`default_nettype wire

@@ src/md5_message_digest.sv @@
// MD5 digest over a byte stream: top level with stream ports.
// A byte that does not fill the block is taken alone; a byte that fills it starts the 64 rounds.
// Last word: pad sweep to byte 63 plus 64 rounds; a length that does not fit adds 64 more
// rounds and a full sweep, a filled block adds 64 more rounds; then 2 digest words.
// Sequential: input is held off during rounds, padding and output; one round per cycle.
// Synchronous active-low reset loads the initial chain words and clears the count.
`timescale 1ns / 1ps
`default_nettype none
module md5_message_digest import md5_pkg::*; (
    input wire i_clk,
    input wire i_rst_n,
    md5_stream_if.sink   i_in,
    md5_stream_if.source o_out
);
    t_cmd  cmd;
    t_stat stat;
    logic  ctl_ready, out_valid, out_hi;
    logic [127:0] dig;

    md5_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_in.valid), .i_has_byte(i_in.data[8]), .i_last_byte(i_in.data[9]),
        .o_ready(ctl_ready), .o_out_valid(out_valid), .o_out_hi(out_hi),
        .i_out_ready(o_out.ready), .o_cmd(cmd), .i_stat(stat)
    );

    md5_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_data_byte(i_in.data[7:0]),
        .i_cmd(cmd), .o_stat(stat), .o_digest(dig)
    );

    assign i_in.ready  = ctl_ready;
    assign o_out.valid = out_valid;
    assign o_out.data  = {out_hi, out_hi ? dig[127:64] : dig[63:0]};
endmodule
`default_nettype wire

@@ tb/sv/md5_message_digest_checker.sv @@
// Checker for the md5 digest block: predicts digests from accepted words and compares.
`timescale 1ns / 1ps
module md5_message_digest_checker import md5_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    input  wire        i_in_ready,
    input  wire [9:0]  i_in_data,
    input  wire        i_out_valid,
    input  wire        i_out_ready,
    input  wire [64:0] i_out_data,
    output int         o_errors,
    output int         o_pending
);
    localparam logic [31:0] SINE_TAB [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };
    localparam int SHIFT_TAB [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                      4, 11, 16, 23, 6, 10, 15, 21};

    logic [31:0] chain [4];
    logic [7:0]  blk [64];
    logic [60:0] byte_cnt;
    logic [64:0] digest_q [$];

    function automatic void chain_reload();
        chain[0] = INIT_A;
        chain[1] = INIT_B;
        chain[2] = INIT_C;
        chain[3] = INIT_D;
    endfunction

    function automatic void compress();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, f, t;
        int g, ph, s;
        for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
        for (int r = 0; r < 64; r++) begin
            ph = r / 16;
            case (ph)
                0: begin f = (b & c) | (~b & d); g = r; end
                1: begin f = (b & d) | (c & ~d); g = (5*r + 1) % 16; end
                2: begin f = b ^ c ^ d;          g = (3*r + 5) % 16; end
                default: begin f = c ^ (b | ~d); g = (7*r) % 16; end
            endcase
            s = SHIFT_TAB[ph*4 + r%4];
            t = a + f + w[g] + SINE_TAB[r];
            t = ((t << s) | (t >> (32 - s))) + b;
            a = d; d = c; c = b; b = t;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
    endfunction

    function automatic void digest_word(logic [7:0] data, logic has, logic last);
        int pos;
        logic [63:0] bit_len;
        if (has) begin
            blk[byte_cnt[5:0]] = data;
            byte_cnt++;
            if (byte_cnt[5:0] == 0)
                compress();
        end
        if (!last)
            return;
        pos = byte_cnt[5:0];
        blk[pos] = PAD_BYTE;
        for (int k = pos + 1; k < 64; k++)
            blk[k] = 8'h00;
        if (pos >= 56) begin
            compress();
            for (int k = 0; k < 56; k++)
                blk[k] = 8'h00;
        end
        bit_len = {byte_cnt, 3'b000};
        for (int k = 0; k < 8; k++)
            blk[56+k] = bit_len[8*k +: 8];
        compress();
        digest_q.push_back({1'b0, chain[1], chain[0]});
        digest_q.push_back({1'b1, chain[3], chain[2]});
        chain_reload();
        byte_cnt = '0;
    endfunction

    always @(posedge i_clk) begin
        logic [64:0] exp_w;
        if (!i_rst_n) begin
            chain_reload();
            byte_cnt = '0;
            digest_q.delete();
            o_errors = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (digest_q.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("unexpected digest word %h", i_out_data);
                end else begin
                    exp_w = digest_q.pop_front();
                    if (exp_w !== i_out_data) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("digest mismatch: exp part %h last %b, got part %h last %b",
                                     exp_w[63:0], exp_w[64], i_out_data[63:0], i_out_data[64]);
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                digest_word(i_in_data[7:0], i_in_data[8], i_in_data[9]);
        end
        o_pending = digest_q.size();
    end
endmodule

@@ tb/sv/md5_message_digest_test.sv @@
// Testbench top for the md5 digest block: stimulus, output stalls and verdict.
`timescale 1ns / 1ps
module md5_message_digest_test;
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   errors, pending;
    int   words_sent, msgs_sent;
    bit   no_idle;

    md5_stream_if #(.Width(10)) in_ch ();
    md5_stream_if #(.Width(65)) out_ch ();

    md5_message_digest u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    md5_message_digest_checker u_chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_ch.valid),
        .i_in_ready (in_ch.ready),
        .i_in_data  (in_ch.data),
        .i_out_valid(out_ch.valid),
        .i_out_ready(out_ch.ready),
        .i_out_data (out_ch.data),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // sink side stalls: mostly short, occasionally long
    initial begin
        int hold;
        @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                hold--;
            end else if (!no_idle && $urandom_range(0, 99) < 25) begin
                out_ch.ready <= 1'b0;
                hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80)
                                                   : $urandom_range(0, 3);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    task automatic send_word(logic [7:0] data, logic has, logic last);
        int gap;
        in_ch.valid <= 1'b1;
        in_ch.data <= {last, has, data};
        // ready is sampled at the edge itself, before the design updates
        @(posedge i_clk iff in_ch.ready);
        words_sent++;
        if (last)
            msgs_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // message of len bytes; last flag rides on the final byte or on a separate empty word
    task automatic send_message(int len, bit separate_end);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 19) == 0)
                send_word(8'($urandom), 1'b0, 1'b0);
            send_word(8'($urandom), 1'b1, (i == len - 1) && !separate_end);
        end
        if (separate_end || len == 0)
            send_word(8'($urandom), 1'b0, 1'b1);
    endtask

    initial begin
        int len;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty message, "abc", idle words, extreme bytes
        send_word(8'hff, 1'b0, 1'b1);
        send_word(8'h00, 1'b0, 1'b0);
        send_word(8'h61, 1'b1, 1'b0);
        send_word(8'h62, 1'b1, 1'b0);
        send_word(8'h63, 1'b1, 1'b1);
        send_word(8'h00, 1'b1, 1'b1);
        send_word(8'hff, 1'b1, 1'b0);
        send_word(8'hff, 1'b0, 1'b0);
        send_word(8'haa, 1'b0, 1'b1);
        send_word(8'h55, 1'b1, 1'b1);

        while (words_sent < 1600) begin
            no_idle = ($urandom_range(0, 9) == 0);
            case ($urandom_range(0, 3))
                0: len = $urandom_range(0, 8);
                1: len = $urandom_range(52, 70);
                2: len = $urandom_range(118, 130);
                default: len = $urandom_range(0, 64);
            endcase
            if ($urandom_range(0, 49) == 0)
                len = $urandom_range(190, 260);
            send_message(len, $urandom_range(0, 2) == 0);
            if (msgs_sent == 10) begin
                in_ch.valid <= 1'b0;
                while (pending != 0)
                    @(posedge i_clk);
            end
        end
        no_idle = 1'b0;
        in_ch.valid <= 1'b0;
        while (pending != 0)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #50ms;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
